>>> rtl/kms_pkg.sv
package kms_pkg;

  localparam int WINDOW_MAX_DEF = 32;
  localparam int KMER_MAX_DEF   = 31;
  localparam int HASH_W         = 62;
  localparam int POS_W          = 32;

  localparam logic [0:0] REG_KMER_LENGTH = 1'b0;
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_EMIT,
    ST_SHIFT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  stop;
    logic              fwd;
  } cand_t;

  // one cell's control, common to all cells of the window row
  typedef struct packed {
    logic load;    // write the new candidate into the cell addressed by the window count (sel)
    logic shift;   // every cell takes its right neighbor's entry; the last cell keeps its own
  } cell_ctl_t;

  // invertible 64-bit mix restricted to the active k-mer bits
  function automatic logic [63:0] mix_hash(input logic [63:0] key_i, input logic [63:0] mask_i);
    logic [63:0] k;
    k = (~key_i + (key_i << 21)) & mask_i;
    k = k ^ (k >> 24);
    k = ((k + (k << 3)) + (k << 8)) & mask_i;
    k = k ^ (k >> 14);
    k = ((k + (k << 2)) + (k << 4)) & mask_i;
    k = k ^ (k >> 28);
    k = (k + (k << 31)) & mask_i;
    return k;
  endfunction

endpackage

>>> rtl/kms_cell.sv
module kms_cell
  import kms_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      sel,
  input  cand_t     new_entry,
  input  cand_t     right_entry,
  output cand_t     entry
);

  cand_t entry_r;

  // shift toward cell 0; load only into the addressed cell
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r <= right_entry;
    end else if (ctl.load && sel) begin
      entry_r <= new_entry;
    end
  end

  assign entry = entry_r;

endmodule

>>> rtl/kmer_minimizer_sketch_core.sv
// kmer minimizer sketch core: one nucleotide word per input handshake, zero or more
// minimizer words out (at most one per window entry, last marks the final one).
// the window lives in a row of WINDOW_MAX cells that shift toward cell 0 by one
// entry per cycle when the window is trimmed. steps per accepted base: hash the
// base; if the window is full, scan it (one cell per cycle) to find the minimum,
// then an emit pass over cells 0 to pos (one cell per cycle while the output is
// free, one output word per tie) and a trim that shifts out cells 0 to pos; else
// a new entry that ties or beats the previous minimum is emitted at once. a new
// base is taken only once the previous one is done; ambiguous bases emit one error
// word, and bases of a too-short sequence go from hash straight back to idle.
// config must be written only while the block is idle; the block does not enforce it.
module kmer_minimizer_sketch_core
  import kms_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int KMER_MAX   = KMER_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [5:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_base,
  input  logic              in_first_base,
  input  logic [31:0]       in_sequence_length,
  input  logic [31:0]       in_position_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] out_minimizer_hash,
  output logic [POS_W-1:0]  out_start_position,
  output logic [POS_W-1:0]  out_end_position,
  output logic              out_forward_strand,
  output logic              out_ambiguous_error,
  output logic              out_last
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  // config registers
  logic [4:0] kmer_length_r;
  logic [5:0] window_size_r;

  // sequence state
  logic [63:0] fwd_kmer_r, rev_kmer_r;
  logic [31:0] bases_seen_r;
  logic [63:0] smallest_r;
  logic [CW-1:0] wcount_r;
  logic too_short_r;
  logic [31:0] offset_r;

  // per-item working registers
  state_t state_r, state_nxt;
  logic [7:0] base_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] pos_r, shift_left_r;
  logic [HASH_W-1:0] min_r;
  logic mode_win_r;    // window full: emit all ties and trim

  // output register
  logic out_valid_r;
  cand_t out_ent_r;
  logic out_err_r, out_last_r;

  // effective k and w
  logic [4:0] k_eff;
  logic [CW-1:0] w_eff;
  always_comb begin
    k_eff = kmer_length_r;
    if (k_eff == 5'd0) k_eff = 5'd1;
    if (32'(k_eff) > KMER_MAX) k_eff = 5'(KMER_MAX);
    if (window_size_r == 6'd0) w_eff = CW'(1);
    else if (32'(window_size_r) > WINDOW_MAX) w_eff = CW'(WINDOW_MAX);
    else w_eff = CW'(window_size_r);
  end

  // k never exceeds 31, so the mask is always 2k ones
  logic [63:0] kmask;
  logic [5:0]  shift1;
  assign kmask  = (64'd1 << {k_eff, 1'b0}) - 64'd1;
  assign shift1 = {k_eff - 5'd1, 1'b0};

  logic [1:0] code;
  logic       ambig;
  always_comb begin
    ambig = 1'b0;
    case (base_r)
      8'h41, 8'h61: code = 2'd0;
      8'h43, 8'h63: code = 2'd1;
      8'h47, 8'h67: code = 2'd2;
      8'h54, 8'h74: code = 2'd3;
      default: begin
        code  = 2'd0;
        ambig = 1'b1;
      end
    endcase
  end

  logic [63:0] fwd_n, rev_n, hf, hr;
  assign fwd_n = ((fwd_kmer_r << 2) | 64'(code)) & kmask;
  assign rev_n = ((rev_kmer_r >> 2) | (64'(~code) << shift1)) & kmask;
  assign hf = mix_hash(fwd_n, kmask);
  assign hr = mix_hash(rev_n, kmask);

  // cell row
  cand_t cells [WINDOW_MAX];
  cand_t new_entry;
  cell_ctl_t ctl;
  logic [31:0] seen_n;
  assign seen_n = bases_seen_r + 32'd1;
  always_comb begin
    new_entry.hash  = (hf < hr) ? hf[HASH_W-1:0] : hr[HASH_W-1:0];
    new_entry.start = seen_n - 32'(k_eff) + offset_r;
    new_entry.stop  = seen_n + offset_r;
    new_entry.fwd   = (hf <= hr);
  end

  logic do_append;
  assign do_append = (state_r == ST_HASH) && !ambig && (seen_n >= 32'(k_eff))
                     && (wcount_r < CW'(WINDOW_MAX));
  assign ctl.load  = do_append;
  assign ctl.shift = (state_r == ST_SHIFT) && (shift_left_r != '0);

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    cand_t right;
    if (g == WINDOW_MAX - 1) begin : g_end
      assign right = cells[g];
    end else begin : g_mid
      assign right = cells[g+1];
    end
    kms_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .sel        (wcount_r[IW-1:0] == IW'(g)),
      .new_entry  (new_entry),
      .right_entry(right),
      .entry      (cells[g])
    );
  end

  cand_t cur;
  assign cur = cells[idx_r];

  logic out_free;
  assign out_free = !out_valid_r || out_ready;
  logic [CW-1:0] wcnt_after;  // count after append in hash cycle
  assign wcnt_after = wcount_r + CW'(do_append);

  logic scan_end, emit_end;
  assign scan_end = (CW'(idx_r) + CW'(1) >= wcount_r);
  assign emit_end = (CW'(idx_r) >= pos_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_HASH;
      ST_HASH: begin
        if (too_short_r) state_nxt = ST_IDLE;
        else if (ambig) state_nxt = ST_ERR;
        else if (wcnt_after >= w_eff) state_nxt = ST_SCAN;
        else if ((33'(seen_n) >= 33'(w_eff) + 33'(k_eff)) && wcnt_after != '0
                 && {2'b00, new_entry.hash} <= smallest_r && do_append)
          state_nxt = ST_EMIT;
        else state_nxt = ST_IDLE;
      end
      ST_SCAN: if (scan_end) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free && (!mode_win_r || emit_end))
                 state_nxt = mode_win_r ? ST_SHIFT : ST_IDLE;
      ST_SHIFT: if (shift_left_r == '0) state_nxt = ST_IDLE;
      ST_ERR: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  // output stage drive
  logic emit_now;
  assign emit_now = (state_r == ST_EMIT) && out_free &&
                    (!mode_win_r || cur.hash == min_r);

  // a new word loads the output register, an accepted one empties it
  logic out_load;
  assign out_load = emit_now || ((state_r == ST_ERR) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      kmer_length_r <= 5'd15;
      window_size_r <= 6'd14;
      fwd_kmer_r    <= '0;
      rev_kmer_r    <= '0;
      bases_seen_r  <= '0;
      smallest_r    <= '1;
      wcount_r      <= '0;
      too_short_r   <= 1'b0;
      offset_r      <= '0;
      idx_r         <= '0;
      pos_r         <= '0;
      shift_left_r  <= '0;
      mode_win_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_KMER_LENGTH: kmer_length_r <= cfg_data[4:0];
          REG_WINDOW_SIZE: window_size_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (in_valid) begin
          base_r <= in_base;
          if (in_first_base) begin
            fwd_kmer_r   <= '0;
            rev_kmer_r   <= '0;
            bases_seen_r <= '0;
            smallest_r   <= '1;
            wcount_r     <= '0;
            offset_r     <= in_position_offset;
            too_short_r  <= (33'(in_sequence_length) + 33'd1) < (33'(w_eff) + 33'(k_eff));
          end
        end
        ST_HASH: if (!too_short_r && !ambig) begin
          fwd_kmer_r   <= fwd_n;
          rev_kmer_r   <= rev_n;
          bases_seen_r <= seen_n;
          wcount_r     <= wcnt_after;
          min_r        <= '1;
          pos_r        <= '0;
          mode_win_r   <= (wcnt_after >= w_eff);
          // immediate emit reads the newest entry, a window pass starts at cell 0
          idx_r        <= (wcnt_after < w_eff) ? IW'(wcnt_after - CW'(1)) : '0;
        end
        ST_SCAN: begin
          if (cur.hash <= min_r) begin
            min_r <= cur.hash;
            pos_r <= CW'(idx_r);
          end
          idx_r <= scan_end ? '0 : idx_r + IW'(1);
        end
        ST_EMIT: if (out_free) begin
          if (emit_now) begin
            out_ent_r   <= cur;
            out_err_r   <= 1'b0;
            out_last_r  <= !mode_win_r || emit_end;
          end
          if (!mode_win_r) begin
            smallest_r <= {2'b00, cur.hash};
            wcount_r   <= '0;
          end else if (emit_end) begin
            smallest_r   <= {2'b00, min_r};
            shift_left_r <= pos_r + CW'(1);
            wcount_r     <= wcount_r - pos_r - CW'(1);
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        ST_SHIFT: if (shift_left_r != '0) shift_left_r <= shift_left_r - CW'(1);
        ST_ERR: if (out_free) begin
          out_ent_r   <= '0;
          out_err_r   <= 1'b1;
          out_last_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_minimizer_hash  = out_ent_r.hash;
  assign out_start_position  = out_ent_r.start;
  assign out_end_position    = out_ent_r.stop;
  assign out_forward_strand  = out_ent_r.fwd;
  assign out_ambiguous_error = out_err_r;
  assign out_last            = out_last_r;

endmodule

>>> rtl/kms_checker.sv
module kms_props (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_ambiguous_error,
  input logic out_last,
  input logic out_forward_strand
);

  // an error word always carries last, as it is the only word of its item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ambiguous_error |-> out_last) else $error("error word without last");

  // error word carries a cleared strand
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ambiguous_error |-> !out_forward_strand) else $error("error strand set");

  // a word is offered only after reset released
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("word after reset");

  // stalled output word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output word dropped");

  // one base at a time: input closes right after an accepted word
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("input open while busy");

endmodule

bind kmer_minimizer_sketch_core kms_props u_kms_props (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_ambiguous_error(out_ambiguous_error),
  .out_last           (out_last),
  .out_forward_strand (out_forward_strand)
);
